### rtl/olspwm_pkg.sv
// Shared constants, types and tables of the open-loop SPWM generator.
package olspwm_pkg;

   // Angle and table geometry
   localparam int ANGLE_BITS       = 32;
   localparam int ANGLE_SHIFT      = 48 - ANGLE_BITS;
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);
   localparam int PHASE_BITS       = 16;

   // Fixed-point constants
   localparam int TURN_SCALE      = 174993;
   localparam int CORDIC_GAIN_Q30 = 652032874;
   localparam int HALF_SQRT3_Q16  = 56756;
   localparam int DT_DEFAULT_US   = 1000;
   localparam int DT_MAX_US       = 500000;
   localparam int CORDIC_ITERS    = 16;
   localparam int ITER_BITS       = $clog2(CORDIC_ITERS);

   // Datapath widths
   localparam int CORDIC_W = 34;
   localparam int TRIG_W   = 18;
   localparam int MUL_A_W  = 43;
   localparam int MUL_B_W  = 21;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int TERM_W   = 35;
   localparam int VOLT_W   = 58;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_TARGET_VELOCITY = 2'd0,
      CSR_DRIVE_VOLTAGE   = 2'd1,
      CSR_SUPPLY_VOLTAGE  = 2'd2,
      CSR_PAIR_COUNT      = 2'd3
   } csr_index_type;

   // Operand selection of the shared multiplier
   typedef enum logic [2:0] {
      MUL_VEL_PP   = 3'd0,
      MUL_DT       = 3'd1,
      MUL_SCALE    = 3'd2,
      MUL_DRIVE_S  = 3'd3,
      MUL_DRIVE_C  = 3'd4,
      MUL_SQRT3    = 3'd5
   } mul_sel_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic        capture;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_en;
      logic        rot_init;
      logic        rot_step;
      logic        round_en;
      logic        out_load;
   } olspwm_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic rot_last;
      logic out_free;
   } olspwm_status_type;

   // Arctangent of 2^-k in units of 2^-32 turn
   function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [ITER_BITS-1:0] k);
      logic signed [CORDIC_W-1:0] r;
      case (k)
         4'd0:    r = 34'sd536870912;
         4'd1:    r = 34'sd316933406;
         4'd2:    r = 34'sd167458907;
         4'd3:    r = 34'sd85004756;
         4'd4:    r = 34'sd42667331;
         4'd5:    r = 34'sd21354465;
         4'd6:    r = 34'sd10679838;
         4'd7:    r = 34'sd5340245;
         4'd8:    r = 34'sd2670163;
         4'd9:    r = 34'sd1335087;
         4'd10:   r = 34'sd667544;
         4'd11:   r = 34'sd333772;
         4'd12:   r = 34'sd166886;
         4'd13:   r = 34'sd83443;
         4'd14:   r = 34'sd41722;
         4'd15:   r = 34'sd20861;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

### rtl/olspwm_ctrl.sv
// Sequencing state machine of the open-loop SPWM generator.
module olspwm_ctrl import olspwm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  olspwm_status_type status,
   output olspwm_cmd_type    cmd
);

   typedef enum logic [11:0] {
      S_IDLE    = 12'b000000000001,
      S_MUL_VP  = 12'b000000000010,
      S_MUL_DT  = 12'b000000000100,
      S_MUL_TS  = 12'b000000001000,
      S_ACC     = 12'b000000010000,
      S_INIT    = 12'b000000100000,
      S_ROT     = 12'b000001000000,
      S_ROUND   = 12'b000010000000,
      S_MUL_S   = 12'b000100000000,
      S_MUL_C   = 12'b001000000000,
      S_MUL_K   = 12'b010000000000,
      S_OUT     = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   // Take a new tick only while idle
   assign req_stall = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mul_sel  = MUL_VEL_PP;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_MUL_VP;
            end
         end
         S_MUL_VP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_VEL_PP;
            state_in    = S_MUL_DT;
         end
         S_MUL_DT: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DT;
            state_in    = S_MUL_TS;
         end
         S_MUL_TS: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SCALE;
            state_in    = S_ACC;
         end
         S_ACC: begin
            cmd.acc_en = 1'b1;
            state_in   = S_INIT;
         end
         S_INIT: begin
            cmd.rot_init = 1'b1;
            state_in     = S_ROT;
         end
         S_ROT: begin
            cmd.rot_step = 1'b1;
            if (status.rot_last) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            state_in     = S_MUL_S;
         end
         S_MUL_S: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DRIVE_S;
            state_in    = S_MUL_C;
         end
         S_MUL_C: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DRIVE_C;
            state_in    = S_MUL_K;
         end
         S_MUL_K: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SQRT3;
            state_in    = S_OUT;
         end
         S_OUT: begin
            // Hold until the result register is free
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/olspwm_datapath.sv
// Registers, shared multiplier, CORDIC and phase voltage output of the SPWM generator.
module olspwm_datapath import olspwm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_write_data,
   input  logic [19:0]       req_elapsed_us,
   input  olspwm_cmd_type    cmd,
   output olspwm_status_type status,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [15:0]       rsp_phase_a,
   output logic [15:0]       rsp_phase_b,
   output logic [15:0]       rsp_phase_c,
   output logic [15:0]       rsp_electrical_phase
);

   localparam logic [47:0] ROUND_ADD = (48'd1 << ANGLE_SHIFT) >> 1;

   // Configuration registers
   logic signed [15:0] velocity_ff;
   logic [15:0]        drive_ff;
   logic [15:0]        supply_ff;
   logic [5:0]         pair_count_ff;

   // Working registers
   logic [19:0]                  dt_ff;
   logic signed [PROD_W-1:0]     prod_ff;
   logic [ANGLE_BITS-1:0]        acc_ff;
   logic signed [CORDIC_W-1:0]   x_ff, y_ff, z_ff;
   logic                         neg_ff;
   logic [ITER_BITS-1:0]         k_ff;
   logic signed [TRIG_W-1:0]     sin_ff, cos_ff;
   logic signed [TERM_W-1:0]     t_ff;

   // Result register
   logic        rsp_valid_ff;
   logic [15:0] phase_a_ff, phase_b_ff, phase_c_ff, phase_e_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         velocity_ff   <= 16'sd768;
         drive_ff      <= 16'd768;
         supply_ff     <= 16'd3072;
         pair_count_ff <= 6'd7;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_TARGET_VELOCITY: velocity_ff   <= $signed(csr_write_data);
            CSR_DRIVE_VOLTAGE:   drive_ff      <= csr_write_data;
            CSR_SUPPLY_VOLTAGE:  supply_ff     <= csr_write_data;
            CSR_PAIR_COUNT:      pair_count_ff <= csr_write_data[5:0];
            default: ;
         endcase
      end
   end

   // Capture the tick, substituting the default for out-of-range elapsed time
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         if (req_elapsed_us == '0 || req_elapsed_us > 20'(DT_MAX_US)) begin
            dt_ff <= 20'(DT_DEFAULT_US);
         end else begin
            dt_ff <= req_elapsed_us;
         end
      end
   end

   // Shared multiplier with operand selection
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;

   always_comb begin
      case (cmd.mul_sel)
         MUL_VEL_PP: begin
            mul_a = MUL_A_W'(velocity_ff);
            mul_b = MUL_B_W'(pair_count_ff);
         end
         MUL_DT: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = MUL_B_W'(dt_ff);
         end
         MUL_SCALE: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = MUL_B_W'(TURN_SCALE);
         end
         MUL_DRIVE_S: begin
            mul_a = MUL_A_W'(drive_ff);
            mul_b = MUL_B_W'(sin_ff);
         end
         MUL_DRIVE_C: begin
            mul_a = MUL_A_W'(drive_ff);
            mul_b = MUL_B_W'(cos_ff);
         end
         MUL_SQRT3: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = MUL_B_W'(HALF_SQRT3_Q16);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_p;
      end
      // Keep the sine term while the cosine product forms
      if (cmd.mul_en && cmd.mul_sel == MUL_DRIVE_C) begin
         t_ff <= prod_ff[TERM_W-1:0];
      end
   end

   // Round the increment to the angle resolution and advance the phase
   logic [47:0] inc_round;
   assign inc_round = prod_ff[47:0] + ROUND_ADD;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_ff + inc_round[47:ANGLE_SHIFT];
      end
   end

   // Quantize the phase to the sine table grid
   logic [PHASE_BITS-1:0]    phase16;
   logic signed [31:0]       table_angle;
   logic signed [CORDIC_W-1:0] z_start;

   assign phase16     = acc_ff[ANGLE_BITS-1 -: PHASE_BITS];
   assign table_angle = {phase16[PHASE_BITS-1 -: SINE_IDX_BITS], (32 - SINE_IDX_BITS)'(0)};
   assign z_start     = CORDIC_W'(table_angle);

   // CORDIC rotation, one iteration per cycle
   logic signed [CORDIC_W-1:0] dx, dy, atan_k;
   assign dx     = y_ff >>> k_ff;
   assign dy     = x_ff >>> k_ff;
   assign atan_k = atan_turn(k_ff);

   assign status.rot_last = (k_ff == ITER_BITS'(CORDIC_ITERS - 1));

   always_ff @(posedge clock) begin
      if (cmd.rot_init) begin
         x_ff <= CORDIC_W'(CORDIC_GAIN_Q30);
         y_ff <= '0;
         k_ff <= '0;
         // Fold the angle into the right half-plane
         if (z_start > (CORDIC_W'(1) <<< 30)) begin
            z_ff   <= z_start - (CORDIC_W'(1) <<< 31);
            neg_ff <= 1'b1;
         end else if (z_start < -(CORDIC_W'(1) <<< 30)) begin
            z_ff   <= z_start + (CORDIC_W'(1) <<< 31);
            neg_ff <= 1'b1;
         end else begin
            z_ff   <= z_start;
            neg_ff <= 1'b0;
         end
      end else if (cmd.rot_step) begin
         k_ff <= k_ff + 1'b1;
         if (z_ff >= 0) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - atan_k;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + atan_k;
         end
      end
   end

   // Round to Q16 and undo the fold
   logic signed [CORDIC_W-1:0] x_rnd, y_rnd;
   logic signed [TRIG_W-1:0]   x_q16, y_q16;
   assign x_rnd = x_ff + CORDIC_W'(8192);
   assign y_rnd = y_ff + CORDIC_W'(8192);
   assign x_q16 = x_rnd[14 +: TRIG_W];
   assign y_q16 = y_rnd[14 +: TRIG_W];

   always_ff @(posedge clock) begin
      if (cmd.round_en) begin
         sin_ff <= neg_ff ? -y_q16 : y_q16;
         cos_ff <= neg_ff ? -x_q16 : x_q16;
      end
   end

   // Inverse Clarke around half supply, in units of 2^-40 V with rounding bias
   logic signed [VOLT_W-1:0] center, t_sh15, t_sh16, p3, va, vb, vc;
   assign center = (VOLT_W'(supply_ff) <<< 31) + (VOLT_W'(1) <<< 31);
   assign t_sh15 = VOLT_W'(t_ff) <<< 15;
   assign t_sh16 = VOLT_W'(t_ff) <<< 16;
   assign p3     = VOLT_W'($signed(prod_ff[51:0]));
   assign va     = center - t_sh16;
   assign vb     = center + t_sh15 + p3;
   assign vc     = center + t_sh15 - p3;

   function automatic logic [15:0] clamp_volts(input logic signed [VOLT_W-1:0] v,
                                               input logic [15:0] sup);
      logic signed [VOLT_W-33:0] q;
      logic [15:0]               r;
      q = v[VOLT_W-1:32];
      if (q < 0) begin
         r = '0;
      end else if (q > $signed({{(VOLT_W-48){1'b0}}, sup})) begin
         r = sup;
      end else begin
         r = q[15:0];
      end
      return r;
   endfunction

   // Result register: load when empty or being taken
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         phase_a_ff <= clamp_volts(va, supply_ff);
         phase_b_ff <= clamp_volts(vb, supply_ff);
         phase_c_ff <= clamp_volts(vc, supply_ff);
         phase_e_ff <= phase16;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_phase_a          = phase_a_ff;
   assign rsp_phase_b          = phase_b_ff;
   assign rsp_phase_c          = phase_c_ff;
   assign rsp_electrical_phase = phase_e_ff;

endmodule

### rtl/open_loop_spwm_generator.sv
// Top level of the open-loop sinusoidal commutation (SPWM) generator.
// Each transfer on the req_ channel is one control tick carrying the microseconds since the
// previous tick (0 or above 500000 counts as 1000). The block advances a 32-bit electrical
// phase by velocity * elapsed * pole pairs, takes sine and cosine of the phase quantized to a
// 1024-step grid with a 16-step CORDIC, and returns three phase voltages in Q8.8 volts,
// centered on half the supply and clamped to 0..supply, together with the top 16 phase bits.
// A tick runs to completion before the next one is accepted: six passes through a single
// shared multiplier, the accumulator update and the 16 CORDIC iterations run one after
// another, and a stalled, still full output register holds it at the end. A finished result
// waits in an output register, and the block already accepts the next tick while it waits. Write the csr_
// registers only while no tick is in progress; a velocity of 0 holds the phase.
module open_loop_spwm_generator import olspwm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [19:0] req_elapsed_us,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_phase_a,
   output logic [15:0] rsp_phase_b,
   output logic [15:0] rsp_phase_c,
   output logic [15:0] rsp_electrical_phase
);

   olspwm_cmd_type    cmd;
   olspwm_status_type status;

   // Sequencer
   olspwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and registers
   olspwm_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_elapsed_us       (req_elapsed_us),
      .cmd                  (cmd),
      .status               (status),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_phase_a          (rsp_phase_a),
      .rsp_phase_b          (rsp_phase_b),
      .rsp_phase_c          (rsp_phase_c),
      .rsp_electrical_phase (rsp_electrical_phase)
   );

endmodule

### dv/tb_open_loop_spwm_generator.sv
// Self-checking testbench of the open-loop SPWM generator: phase and voltage scoreboard, drivers.
`timescale 1ns / 100ps

// One result transfer: three phase voltages and the top phase bits
typedef struct packed {
   logic [15:0] phase_a;
   logic [15:0] phase_b;
   logic [15:0] phase_c;
   logic [15:0] electrical_phase;
} phase_volts_type;

// Tracks register values and the electrical phase, and predicts the voltages of each tick
class phase_voltage_scoreboard;
   localparam longint TURN_SCALE_Q48   = 174993;
   localparam longint CORDIC_GAIN_Q30  = 652032874;
   localparam longint SQRT3_HALF_Q16   = 56756;
   localparam longint QUARTER_TURN     = 64'sd1073741824;
   localparam longint HALF_TURN        = 64'sd2147483648;
   localparam longint ELAPSED_CAP_US   = 500000;
   localparam longint ELAPSED_SUBST_US = 1000;

   // arctan(2^-k) in 2^-32 turn
   longint atan_turns[16] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861
   };

   logic signed [15:0] velocity;
   logic [15:0]        drive;
   logic [15:0]        supply;
   logic [5:0]         pair_count;
   logic [31:0]        phase_acc;
   phase_volts_type    pending_volts[$];
   int                 resolved;
   int                 errors;

   function new();
      velocity   = 16'sd768;
      drive      = 16'd768;
      supply     = 16'd3072;
      pair_count = 6'd7;
      phase_acc  = '0;
      resolved   = 0;
      errors     = 0;
   endfunction

   // Mirror a register write
   function void set_reg(input olspwm_pkg::csr_index_type idx, input logic [15:0] data);
      case (idx)
         olspwm_pkg::CSR_TARGET_VELOCITY: velocity = data;
         olspwm_pkg::CSR_DRIVE_VOLTAGE:   drive = data;
         olspwm_pkg::CSR_SUPPLY_VOLTAGE:  supply = data;
         olspwm_pkg::CSR_PAIR_COUNT:      pair_count = data[5:0];
         default: ;
      endcase
   endfunction

   // Rotation CORDIC on a 2^-32 turn angle; sine and cosine in Q16
   function void sincos_q16(input logic [31:0] angle, output longint sin_q16,
                            output longint cos_q16);
      longint z, x, y, dx, dy;
      bit     flip;
      z = $signed(angle);
      flip = 1'b0;
      // fold the left half plane onto the right one and negate afterwards
      if (z > QUARTER_TURN) begin
         z -= HALF_TURN;
         flip = 1'b1;
      end else if (z < -QUARTER_TURN) begin
         z += HALF_TURN;
         flip = 1'b1;
      end
      x = CORDIC_GAIN_Q30;
      y = 0;
      for (int k = 0; k < 16; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= atan_turns[k];
         end else begin
            x += dx;
            y -= dy;
            z += atan_turns[k];
         end
      end
      x = (x + 8192) >>> 14;
      y = (y + 8192) >>> 14;
      if (flip) begin
         x = -x;
         y = -y;
      end
      sin_q16 = y;
      cos_q16 = x;
   endfunction

   // Round a 2^-40 V value to Q8.8 and clamp to the supply
   function logic [15:0] to_q8_8(input longint v40);
      longint q;
      q = (v40 + HALF_TURN) >>> 32;
      if (q < 0) q = 0;
      if (q > longint'(supply)) q = longint'(supply);
      return 16'(q);
   endfunction

   // Advance the phase by one accepted tick and queue its voltages
   function void note_tick(input logic [19:0] us);
      longint          dt, turn_step, sin_q16, cos_q16, uq, alpha, beta, center;
      logic [63:0]     advance;
      logic [15:0]     phase16;
      phase_volts_type want;
      dt = longint'(us);
      if (dt == 0 || dt > ELAPSED_CAP_US) dt = ELAPSED_SUBST_US;
      turn_step = longint'(velocity) * dt * longint'(pair_count) * TURN_SCALE_Q48;
      advance = turn_step;
      advance = (advance + 64'h8000) >> 16;
      phase_acc = phase_acc + advance[31:0];
      phase16 = phase_acc[31:16];
      // table grid of 1024 steps
      sincos_q16({phase16[15:6], 22'd0}, sin_q16, cos_q16);
      uq = longint'(drive);
      alpha = -(uq * sin_q16);
      beta = uq * cos_q16;
      center = longint'(supply) * HALF_TURN;
      want.phase_a = to_q8_8(alpha * 65536 + center);
      want.phase_b = to_q8_8(-alpha * 32768 + beta * SQRT3_HALF_Q16 + center);
      want.phase_c = to_q8_8(-alpha * 32768 - beta * SQRT3_HALF_Q16 + center);
      want.electrical_phase = phase16;
      pending_volts.push_back(want);
   endfunction

   task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   task compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
      if (got !== want)
         report($sformatf("tick %0d %s: got %0d, expected %0d", resolved, name, got, want));
   endtask

   // Match a result transfer against the oldest outstanding tick
   task check_result(input phase_volts_type got);
      phase_volts_type want;
      if (pending_volts.size() == 0) begin
         report($sformatf("result with no tick outstanding: phase %0d", got.electrical_phase));
      end else begin
         want = pending_volts.pop_front();
         resolved++;
         compare_field("phase_a", got.phase_a, want.phase_a);
         compare_field("phase_b", got.phase_b, want.phase_b);
         compare_field("phase_c", got.phase_c, want.phase_c);
         compare_field("electrical_phase", got.electrical_phase, want.electrical_phase);
      end
   endtask
endclass

module tb_open_loop_spwm_generator;
   import olspwm_pkg::*;

   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_OFF      = 400;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_TICKS   = 156;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic [19:0] req_elapsed_us;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_phase_a;
   logic [15:0] rsp_phase_b;
   logic [15:0] rsp_phase_c;
   logic [15:0] rsp_electrical_phase;

   phase_voltage_scoreboard voltage_board;
   int sent;
   int gap_pct;
   int stall_pct;
   bit calm;
   bit squeeze_req;

   open_loop_spwm_generator uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one tick, with an optional idle burst ahead of it, and hold until transfer
   task automatic send_tick(input logic [19:0] us);
      if (!calm && $urandom_range(1, 100) <= gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_elapsed_us <= us;
      do @(posedge clock); while (req_stall);
      voltage_board.note_tick(us);
      sent++;
   endtask

   // Drop valid and wait until every tick has its result
   task automatic await_results();
      req_valid <= 1'b0;
      while (voltage_board.resolved < sent) @(posedge clock);
   endtask

   task automatic put_reg(input csr_index_type idx, input logic [15:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      voltage_board.set_reg(idx, data);
   endtask

   // Write all four registers; upper bits of the pole pair word are junk
   task automatic program_regs(input logic [15:0] vel, input logic [15:0] drv,
                               input logic [15:0] sup, input logic [5:0] pp);
      put_reg(CSR_TARGET_VELOCITY, vel);
      put_reg(CSR_DRIVE_VOLTAGE, drv);
      put_reg(CSR_SUPPLY_VOLTAGE, sup);
      put_reg(CSR_PAIR_COUNT, {10'($urandom), pp});
      csr_write_en <= 1'b0;
   endtask

   task automatic random_regs();
      logic [15:0] vel, drv, sup;
      logic [5:0]  pp;
      case ($urandom_range(0, 5))
         0:       vel = 16'h8000;
         1:       vel = 16'h7FFF;
         2:       vel = 16'h0000;
         default: vel = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0:       drv = 16'h0000;
         1:       drv = 16'hFFFF;
         2:       drv = 16'($urandom);
         default: drv = 16'($urandom_range(0, 4096));
      endcase
      case ($urandom_range(0, 4))
         0:       sup = 16'h0000;
         1:       sup = 16'hFFFF;
         2:       sup = 16'($urandom);
         default: sup = 16'($urandom_range(1024, 16384));
      endcase
      case ($urandom_range(0, 5))
         0:       pp = 6'd0;
         1:       pp = 6'($urandom_range(33, 63));
         default: pp = 6'($urandom_range(1, 32));
      endcase
      program_regs(vel, drv, sup, pp);
   endtask

   // Mostly realistic tick spacing, some out of range, some fully random
   function automatic logic [19:0] random_elapsed();
      case ($urandom_range(0, 9))
         0:       return 20'd0;
         1:       return 20'($urandom_range(500001, 1048575));
         2:       return 20'($urandom);
         default: return 20'($urandom_range(1, 3000));
      endcase
   endfunction

   // Receiver: random stall bursts, plus one long hold-off on request
   initial begin : result_sink
      int span;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze_req) begin
            squeeze_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(1, 100) <= stall_pct) begin
            span = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
            repeat (span) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         voltage_board.check_result({rsp_phase_a, rsp_phase_b, rsp_phase_c,
                                     rsp_electrical_phase});
   end

   // Abort when nothing moves on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("[open_loop_spwm_generator] ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [19:0] corners[10];
      voltage_board = new();
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index <= CSR_TARGET_VELOCITY;
      csr_write_data <= '0;
      req_valid <= 1'b0;
      req_elapsed_us <= '0;
      sent = 0;
      gap_pct = 25;
      stall_pct = 10;
      calm = 1'b0;
      squeeze_req = 1'b0;
      corners = '{20'd0, 20'd1, 20'd2, 20'd999, 20'd1000, 20'd499999, 20'd500000,
                  20'd500001, 20'd524288, 20'd1048575};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // elapsed time corners on the register reset values
      foreach (corners[i]) send_tick(corners[i]);
      await_results();

      // stop: zero velocity holds the phase
      program_regs(16'h0000, 16'd768, 16'd3072, 6'd7);
      send_tick(20'd1000);
      send_tick(20'd1048575);
      await_results();

      // zero pole pairs freeze the phase even at full speed
      program_regs(16'h7FFF, 16'd768, 16'd3072, 6'd0);
      send_tick(20'd500000);
      send_tick(20'd1);
      await_results();

      // most negative speed, pole pairs out of range, zero supply
      program_regs(16'h8000, 16'hFFFF, 16'h0000, 6'd63);
      send_tick(20'd333);
      send_tick(20'd500000);
      send_tick(20'd77777);
      await_results();

      // zero drive sits on the center of a full-scale supply
      program_regs(16'h7FFF, 16'h0000, 16'hFFFF, 6'd32);
      send_tick(20'd4321);
      send_tick(20'd499999);
      send_tick(20'd0);
      await_results();

      // full drive saturates against the supply
      program_regs(16'h7FFF, 16'hFFFF, 16'hFFFF, 6'd1);
      send_tick(20'd499999);
      send_tick(20'd12345);
      send_tick(20'd1);
      await_results();

      // random register settings; a long receiver hold-off in one phase, no idling at the end
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         random_regs();
         gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 30);
         if (p >= RANDOM_PHASES - 2) calm = 1'b1;
         if (p == 1) squeeze_req = 1'b1;
         repeat (PHASE_TICKS) send_tick(random_elapsed());
         await_results();
      end

      // let any stray result show up
      repeat (64) @(posedge clock);
      if (voltage_board.pending_volts.size() != 0)
         voltage_board.report($sformatf("%0d ticks without result",
                                        voltage_board.pending_volts.size()));
      if (voltage_board.errors == 0) $display("[open_loop_spwm_generator] OK");
      else $display("[open_loop_spwm_generator] ERROR");
      $finish;
   end

endmodule
